// File: design/bsstk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsstk_pkg: shared definitions for the bounded sortable stack
// Operation and status codes, the stored entry layout, the cell load
// selects and the sequencer state encoding.
// ----------------------------------------------------------------------------
package bsstk_pkg;

  // Default stack depth.
  localparam int DEPTH_DEF = 4;

  // Field widths fixed by the interface.
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 16;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 3;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_SORT = 2'd3
  } op_t;

  // Status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  // One stored entry.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  // Load select of one cell.
  typedef enum logic [1:0] {
    SEL_HOLD    = 2'd0,
    SEL_FROM_UP = 2'd1,
    SEL_FROM_DN = 2'd2
  } sel_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    SQ_IDLE = 3'b001,
    SQ_SORT = 3'b010,
    SQ_LIST = 3'b100
  } seq_state_t;

endpackage : bsstk_pkg
`default_nettype wire

// File: design/bounded_sortable_stack_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_sortable_stack_core: LIFO stack with a stable ascending sort
// A chain of DEPTH cells, cell 0 the top. Push and pop shift the chain,
// sort runs odd-even transposition passes, listing rotates the chain.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                         | Direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid in_ready in_op in_price_key in_item_tag | to core
//  out     | out_valid out_ready out_status out_key out_tag   | from core
//          | out_entry_count out_last_result                  |
//
// Push, pop and peek have their result registered at accept.
// Sort runs DEPTH transposition passes over the cell chain, then
// DEPTH rotation steps of the chain, one result per stored entry on the
// first steps; a listing step waits while the output register is full.
// A new transaction is taken once the sequencer is idle and the output
// register is free or being drained.
// Reset clears the fill count, the sequencer and the output valid; cell
// contents are not reset and are never read beyond the fill count.
// ----------------------------------------------------------------------------
module bounded_sortable_stack_core #(
  parameter int DEPTH = bsstk_pkg::DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [bsstk_pkg::OP_W-1:0]         in_op,
  input  wire logic signed [bsstk_pkg::KEY_W-1:0] in_price_key,
  input  wire logic [bsstk_pkg::TAG_W-1:0]        in_item_tag,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [bsstk_pkg::STATUS_W-1:0]          out_status,
  output logic signed [bsstk_pkg::KEY_W-1:0]      out_key,
  output logic [bsstk_pkg::TAG_W-1:0]             out_tag,
  output logic [bsstk_pkg::COUNT_W-1:0]           out_entry_count,
  output logic                                    out_last_result
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RND_W = $clog2(DEPTH);

  // Control state.
  bsstk_pkg::seq_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [RND_W-1:0]      rnd_r, rnd_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Output payload registers.
  bsstk_pkg::status_t    status_r, status_nxt;
  bsstk_pkg::entry_t     res_r, res_nxt;
  logic                  last_r, last_nxt;

  // Cell chain.
  bsstk_pkg::entry_t     cell_q [DEPTH];
  bsstk_pkg::sel_t       sel [DEPTH];
  logic [DEPTH:0]        swp_ext;
  bsstk_pkg::entry_t     push_entry;

  logic                  out_free;
  logic                  in_fire;
  logic                  full;
  logic                  empty;
  logic                  push_go;
  logic                  pop_go;
  logic                  sort_on;
  logic                  list_pending;
  logic                  list_step;
  logic                  list_emit;
  bsstk_pkg::op_t        op;

  assign op         = bsstk_pkg::op_t'(in_op);
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == bsstk_pkg::SQ_IDLE) && out_free;
  assign in_fire    = in_valid && in_ready;
  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign empty      = (cnt_r == '0);
  assign push_go    = in_fire && (op == bsstk_pkg::OP_PUSH) && !full;
  assign pop_go     = in_fire && (op == bsstk_pkg::OP_POP) && !empty;
  assign sort_on    = (state_r == bsstk_pkg::SQ_SORT);

  // While listing, the rotation index still points at a stored entry.
  assign list_pending = (CNT_W'(rnd_r) < cnt_r);
  assign list_step    = (state_r == bsstk_pkg::SQ_LIST) && (!list_pending || out_free);
  assign list_emit    = (state_r == bsstk_pkg::SQ_LIST) && list_pending && out_free;

  assign push_entry.key = in_price_key;
  assign push_entry.tag = in_item_tag;

  // Pair exchange decisions: pairs of one parity per pass, stored pairs only.
  assign swp_ext[0]     = 1'b0;
  assign swp_ext[DEPTH] = 1'b0;

  for (genvar p = 0; p < DEPTH - 1; p++) begin : g_pair
    localparam bit PAR = (p % 2) == 1;
    logic pair_en;
    assign pair_en = sort_on && (rnd_r[0] == PAR) && (CNT_W'(p + 1) < cnt_r);
    bsstk_cmp u_cmp (
      .en      (pair_en),
      .upper_i (cell_q[p]),
      .lower_i (cell_q[p+1]),
      .swap_o  (swp_ext[p+1])
    );
  end

  // Cells with their load selects.
  for (genvar c = 0; c < DEPTH; c++) begin : g_cell
    bsstk_pkg::entry_t up_d;
    bsstk_pkg::entry_t dn_d;

    if (c == 0) begin : g_top
      assign up_d = push_entry;
    end else begin : g_mid
      assign up_d = cell_q[c-1];
    end

    // The bottom cell takes the top entry, closing the ring for rotation.
    if (c == DEPTH - 1) begin : g_bot
      assign dn_d = cell_q[0];
    end else begin : g_nbot
      assign dn_d = cell_q[c+1];
    end

    always_comb begin
      priority if (push_go) begin
        sel[c] = bsstk_pkg::SEL_FROM_UP;
      end else if (pop_go || list_step) begin
        sel[c] = bsstk_pkg::SEL_FROM_DN;
      end else if (swp_ext[c+1]) begin
        sel[c] = bsstk_pkg::SEL_FROM_DN;
      end else if (swp_ext[c]) begin
        sel[c] = bsstk_pkg::SEL_FROM_UP;
      end else begin
        sel[c] = bsstk_pkg::SEL_HOLD;
      end
    end

    bsstk_cell u_cell (
      .clk    (clk),
      .sel    (sel[c]),
      .up_i   (up_d),
      .dn_i   (dn_d),
      .data_o (cell_q[c])
    );
  end

  // Sequencer, fill count and output register.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    res_nxt       = res_r;
    last_nxt      = last_r;

    unique case (state_r)
      bsstk_pkg::SQ_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          status_nxt    = bsstk_pkg::ST_OK;
          res_nxt       = '0;
          last_nxt      = 1'b1;
          unique case (op)
            bsstk_pkg::OP_PUSH: begin
              if (full) begin
                status_nxt = bsstk_pkg::ST_OVERFLOW;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            bsstk_pkg::OP_POP: begin
              if (empty) begin
                status_nxt = bsstk_pkg::ST_EMPTY;
              end else begin
                res_nxt = cell_q[0];
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            bsstk_pkg::OP_PEEK: begin
              if (empty) begin
                status_nxt = bsstk_pkg::ST_EMPTY;
              end else begin
                res_nxt = cell_q[0];
              end
            end
            default: begin
              if (empty) begin
                status_nxt = bsstk_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = bsstk_pkg::SQ_SORT;
                rnd_nxt       = '0;
              end
            end
          endcase
        end
      end

      bsstk_pkg::SQ_SORT: begin
        if (rnd_r == RND_W'(DEPTH - 1)) begin
          state_nxt = bsstk_pkg::SQ_LIST;
          rnd_nxt   = '0;
        end else begin
          rnd_nxt = rnd_r + 1'b1;
        end
      end

      bsstk_pkg::SQ_LIST: begin
        if (list_emit) begin
          out_valid_nxt = 1'b1;
          status_nxt    = bsstk_pkg::ST_OK;
          res_nxt       = cell_q[0];
          last_nxt      = (CNT_W'(rnd_r) + 1'b1 == cnt_r);
        end
        if (list_step) begin
          if (rnd_r == RND_W'(DEPTH - 1)) begin
            state_nxt = bsstk_pkg::SQ_IDLE;
            rnd_nxt   = '0;
          end else begin
            rnd_nxt = rnd_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = bsstk_pkg::SQ_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsstk_pkg::SQ_IDLE;
      cnt_r       <= '0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload registers.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    res_r    <= res_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_key         = res_r.key;
  assign out_tag         = res_r.tag;
  assign out_entry_count = bsstk_pkg::COUNT_W'(cnt_r);
  assign out_last_result = last_r;

  // The fill count never passes the depth.
  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // A sort pass only runs on a non-empty stack.
  a_sort_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != bsstk_pkg::SQ_IDLE) |-> (cnt_r != '0))
    else $error("sort sequence on empty stack");

  // A push that fits grows the count by one.
  a_push_count : assert property (@(posedge clk) disable iff (!rst_n)
    push_go |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("push did not grow fill count");

  // Sort and listing never change the count.
  a_list_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != bsstk_pkg::SQ_IDLE) |=> $stable(cnt_r))
    else $error("fill count changed during sort");

  // A listed result never overwrites one still waiting.
  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    list_emit |-> (!out_valid_r || out_ready))
    else $error("listing overran output register");

endmodule : bounded_sortable_stack_core
`default_nettype wire

// File: design/bsstk_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsstk_cell: one storage cell of the stack chain
// Holds one entry and each cycle keeps it, or takes the entry of the cell
// above or the cell below.
// ----------------------------------------------------------------------------
module bsstk_cell (
  input  wire logic             clk,
  input  wire bsstk_pkg::sel_t  sel,
  input  wire bsstk_pkg::entry_t up_i,
  input  wire bsstk_pkg::entry_t dn_i,
  output bsstk_pkg::entry_t     data_o
);

  bsstk_pkg::entry_t data_r;
  bsstk_pkg::entry_t data_nxt;

  // Pick the next content from the neighbor named by the select.
  always_comb begin
    unique case (sel)
      bsstk_pkg::SEL_FROM_UP: data_nxt = up_i;
      bsstk_pkg::SEL_FROM_DN: data_nxt = dn_i;
      default:                data_nxt = data_r;
    endcase
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule : bsstk_cell
`default_nettype wire

// File: design/bsstk_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsstk_cmp: exchange decision for one pair of neighboring cells
// Requests a swap when the lower cell holds a strictly smaller key, which
// keeps equal keys in their order.
// ----------------------------------------------------------------------------
module bsstk_cmp (
  input  wire logic              en,
  input  wire bsstk_pkg::entry_t upper_i,
  input  wire bsstk_pkg::entry_t lower_i,
  output logic                   swap_o
);

  // Signed compare of the two keys.
  assign swap_o = en && ($signed(lower_i.key) < $signed(upper_i.key));

endmodule : bsstk_cmp
`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for bounded_sortable_stack_core
// A driver works through a queue of stack operations on the input channel.
// A shadow stack predicts every transaction on the result channel. A monitor
// compares each result field by field with the oldest prediction. Both
// channels idle and stall at random, in phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH     = bsstk_pkg::DEPTH_DEF;
  localparam int KEY_W     = bsstk_pkg::KEY_W;
  localparam int TAG_W     = bsstk_pkg::TAG_W;
  localparam int OP_W      = bsstk_pkg::OP_W;
  localparam int STATUS_W  = bsstk_pkg::STATUS_W;
  localparam int COUNT_W   = bsstk_pkg::COUNT_W;
  localparam int HOLD_LEN  = 60;
  localparam int RUN_LIMIT = 2_000_000;

  // One operation waiting to be sent, with the pacing that goes with it.
  typedef struct {
    bsstk_pkg::op_t          op;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    int                      send_idle;
    int                      recv_stall;
    bit                      hold;
    bit                      drain;
  } stack_op_t;

  // One predicted result transaction.
  typedef struct {
    bsstk_pkg::status_t      status;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } stack_result_t;

  logic                      clk;
  logic                      rst_n           = 1'b0;
  logic                      in_valid        = 1'b0;
  logic                      in_ready;
  logic [OP_W-1:0]           in_op           = bsstk_pkg::OP_PUSH;
  logic signed [KEY_W-1:0]   in_price_key    = '0;
  logic [TAG_W-1:0]          in_item_tag     = '0;
  logic                      out_valid;
  logic                      out_ready       = 1'b0;
  logic [STATUS_W-1:0]       out_status;
  logic signed [KEY_W-1:0]   out_key;
  logic [TAG_W-1:0]          out_tag;
  logic [COUNT_W-1:0]        out_entry_count;
  logic                      out_last_result;

  stack_op_t     op_queue[$];
  stack_result_t result_queue[$];
  stack_op_t     offered_op;

  // Shadow copy of the stack contents.
  bsstk_pkg::entry_t shadow_slots[DEPTH];
  int            shadow_fill = 0;

  int            results_predicted = 0;
  int            results_seen      = 0;
  int            mismatches        = 0;
  int            stall_pct         = 0;
  int            hold_left         = 0;
  logic          hold_req          = 1'b0;

  // Pacing applied to operations as they are queued.
  int            phase_send_idle   = 0;
  int            phase_recv_stall  = 0;

  // Driver-side scratch.
  logic          next_valid;
  logic          next_hold;
  int            next_stall;
  int            outstanding;
  bit            may_offer;
  stack_result_t seen;
  stack_result_t want;

  bounded_sortable_stack_core #(.DEPTH(DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_price_key    (in_price_key),
    .in_item_tag     (in_item_tag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_key         (out_key),
    .out_tag         (out_tag),
    .out_entry_count (out_entry_count),
    .out_last_result (out_last_result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Queue one predicted result.
  function automatic void add_result(bsstk_pkg::status_t st,
                                     logic signed [KEY_W-1:0] key,
                                     logic [TAG_W-1:0] tag, logic last);
    stack_result_t r;
    r.status = st;
    r.key    = key;
    r.tag    = tag;
    r.count  = COUNT_W'(shadow_fill);
    r.last   = last;
    result_queue.push_back(r);
    results_predicted++;
  endfunction

  // Apply one accepted operation to the shadow stack and predict its results.
  function automatic void run_stack_op(stack_op_t s);
    bsstk_pkg::entry_t ordered[DEPTH];
    bsstk_pkg::entry_t moving;
    int     i;
    int     j;
    case (s.op)
      bsstk_pkg::OP_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          add_result(bsstk_pkg::ST_OVERFLOW, '0, '0, 1'b1);
        end else begin
          shadow_slots[shadow_fill].key = s.key;
          shadow_slots[shadow_fill].tag = s.tag;
          shadow_fill++;
          add_result(bsstk_pkg::ST_OK, '0, '0, 1'b1);
        end
      end
      bsstk_pkg::OP_POP: begin
        if (shadow_fill == 0) begin
          add_result(bsstk_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          shadow_fill--;
          add_result(bsstk_pkg::ST_OK, shadow_slots[shadow_fill].key,
                     shadow_slots[shadow_fill].tag, 1'b1);
        end
      end
      bsstk_pkg::OP_PEEK: begin
        if (shadow_fill == 0) begin
          add_result(bsstk_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          add_result(bsstk_pkg::ST_OK, shadow_slots[shadow_fill-1].key,
                     shadow_slots[shadow_fill-1].tag, 1'b1);
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          add_result(bsstk_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          // Top first, then a stable insertion sort: only a strictly smaller
          // key moves past another one.
          for (i = 0; i < shadow_fill; i++) ordered[i] = shadow_slots[shadow_fill-1-i];
          for (i = 1; i < shadow_fill; i++) begin
            moving = ordered[i];
            j = i;
            while (j > 0 && $signed(moving.key) < $signed(ordered[j-1].key)) begin
              ordered[j] = ordered[j-1];
              j--;
            end
            ordered[j] = moving;
          end
          for (i = 0; i < shadow_fill; i++) begin
            shadow_slots[shadow_fill-1-i] = ordered[i];
            add_result(bsstk_pkg::ST_OK, ordered[i].key, ordered[i].tag,
                       i == shadow_fill - 1);
          end
        end
      end
    endcase
  endfunction

  // Queue an operation with the current pacing.
  function automatic void queue_op(bsstk_pkg::op_t op, logic signed [KEY_W-1:0] key,
                                   logic [TAG_W-1:0] tag);
    stack_op_t s;
    s.op         = op;
    s.key        = key;
    s.tag        = tag;
    s.send_idle  = phase_send_idle;
    s.recv_stall = phase_recv_stall;
    s.hold       = 1'b0;
    s.drain      = 1'b0;
    op_queue.push_back(s);
  endfunction

  // Keys lean toward a few repeated prices so that ties are common.
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0, 1, 2, 3: return KEY_W'(($signed($urandom_range(4)) - 2) * 100);
      4:          return 32'sh7fff_ffff;
      5:          return 32'sh8000_0000;
      default:    return $signed($urandom);
    endcase
  endfunction

  // Random operation mix that keeps the stack moving through all fill levels.
  function automatic void queue_random_op();
    int             pick;
    bsstk_pkg::op_t op;
    pick = $urandom_range(99);
    if (pick < 42)      op = bsstk_pkg::OP_PUSH;
    else if (pick < 66) op = bsstk_pkg::OP_POP;
    else if (pick < 80) op = bsstk_pkg::OP_PEEK;
    else                op = bsstk_pkg::OP_SORT;
    queue_op(op, pick_key(), 16'($urandom));
  endfunction

  // A burst with a long receiver hold-off, then a pause until all is drained.
  function automatic void queue_pressure_burst();
    int k;
    queue_op(bsstk_pkg::OP_PUSH, pick_key(), 16'($urandom));
    op_queue[$].hold = 1'b1;
    for (k = 0; k < 10; k++) begin
      queue_op((k % 3 == 2) ? bsstk_pkg::OP_SORT : bsstk_pkg::OP_PUSH,
               pick_key(), 16'($urandom));
    end
    queue_op(bsstk_pkg::OP_PEEK, '0, '0);
    op_queue[$].drain = 1'b1;
  endfunction

  function automatic void build_stimulus();
    int phase;
    int k;
    // Empty stack cases.
    queue_op(bsstk_pkg::OP_PEEK, 32'sh1234_5678, 16'hffff);
    queue_op(bsstk_pkg::OP_POP,  '0, '0);
    queue_op(bsstk_pkg::OP_SORT, '0, '0);
    // Field extremes, filling the stack, then a push to a full stack.
    queue_op(bsstk_pkg::OP_PUSH, 32'sh7fff_ffff, 16'hffff);
    queue_op(bsstk_pkg::OP_PUSH, 32'sh8000_0000, 16'h0000);
    queue_op(bsstk_pkg::OP_PUSH, 32'sh0000_0000, 16'h5a5a);
    queue_op(bsstk_pkg::OP_PUSH, -32'sd1,        16'ha5a5);
    queue_op(bsstk_pkg::OP_PUSH, 32'sd777,       16'h0001);
    queue_op(bsstk_pkg::OP_PEEK, '0, '0);
    queue_op(bsstk_pkg::OP_SORT, '0, '0);
    for (k = 0; k < DEPTH; k++) queue_op(bsstk_pkg::OP_POP, '0, '0);
    queue_op(bsstk_pkg::OP_POP, '0, '0);
    // Equal keys must keep their order from the top.
    queue_op(bsstk_pkg::OP_PUSH, 32'sd500, 16'h000a);
    queue_op(bsstk_pkg::OP_PUSH, 32'sd500, 16'h000b);
    queue_op(bsstk_pkg::OP_PUSH, -32'sd300, 16'h000c);
    queue_op(bsstk_pkg::OP_PUSH, 32'sd500, 16'h000d);
    queue_op(bsstk_pkg::OP_SORT, '0, '0);
    queue_op(bsstk_pkg::OP_SORT, '0, '0);
    queue_op(bsstk_pkg::OP_POP,  '0, '0);
    queue_op(bsstk_pkg::OP_POP,  '0, '0);
    queue_op(bsstk_pkg::OP_POP,  '0, '0);
    queue_op(bsstk_pkg::OP_SORT, '0, '0);

    // Random phases with different idling on each side.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        1:       begin phase_send_idle = 62; phase_recv_stall = 0;  end
        2:       begin phase_send_idle = 0;  phase_recv_stall = 62; end
        3:       begin phase_send_idle = 7;  phase_recv_stall = 7;  end
        default: begin phase_send_idle = 0;  phase_recv_stall = 0;  end
      endcase
      if (phase == 0 || phase == 4) begin
        queue_pressure_burst();
      end
      for (k = 0; k < 40; k++) queue_random_op();
    end
  endfunction

  // Driver: offers queued operations and predicts each accepted one.
  always @(posedge clk) begin
    next_valid = in_valid;
    next_hold  = 1'b0;
    next_stall = stall_pct;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        run_stack_op(offered_op);
        next_valid = 1'b0;
      end
      if (!next_valid && op_queue.size() > 0) begin
        outstanding = results_predicted - results_seen - ((out_valid && out_ready) ? 1 : 0);
        if (op_queue[0].drain) may_offer = (outstanding == 0);
        else                   may_offer = ($urandom_range(99) >= op_queue[0].send_idle);
        if (may_offer) begin
          offered_op = op_queue.pop_front();
          next_valid = 1'b1;
          next_hold  = offered_op.hold;
          next_stall = offered_op.recv_stall;
        end
      end
    end
    in_valid     <= next_valid;
    in_op        <= offered_op.op;
    in_price_key <= offered_op.key;
    in_item_tag  <= offered_op.tag;
    hold_req     <= next_hold;
    stall_pct    <= next_stall;
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each result transaction and drives the receiver stalls.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (result_queue.size() == 0) begin
        $error("unexpected result: status %0d key %0d tag %0h",
               out_status, out_key, out_tag);
        mismatches++;
      end else begin
        want = result_queue.pop_front();
        seen.status = bsstk_pkg::status_t'(out_status);
        seen.key    = out_key;
        seen.tag    = out_tag;
        seen.count  = out_entry_count;
        seen.last   = out_last_result;
        if (seen.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (seen.key !== want.key) begin
          $error("out_key: expected %0d, got %0d", want.key, out_key);
          mismatches++;
        end
        if (seen.tag !== want.tag) begin
          $error("out_tag: expected %0h, got %0h", want.tag, out_tag);
          mismatches++;
        end
        if (seen.count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, out_entry_count);
          mismatches++;
        end
        if (seen.last !== want.last) begin
          $error("last_result: expected %0b, got %0b", want.last, out_last_result);
          mismatches++;
        end
      end
      results_seen <= results_seen + 1;
    end
    out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  // Reset, stimulus and end of run.
  initial begin
    build_stimulus();
    offered_op = op_queue[0];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (op_queue.size() != 0 || in_valid || results_seen != results_predicted);
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (result_queue.size() != 0) begin
      $error("%0d expected results never arrived", result_queue.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #(RUN_LIMIT);
    $display("tb_top failed");
    $finish;
  end

endmodule

// File: sim.f
design/bsstk_pkg.sv
design/bsstk_cell.sv
design/bsstk_cmp.sv
design/bounded_sortable_stack_core.sv
tb/tb_top.sv
